[hw/rtl/wsp_pkg.sv]
package wsp_pkg;

	// counter and result limits
	localparam int CNT_W = 24;
	localparam int SPEED_W = 16;
	localparam int RADIUS_W = 10;
	localparam int TEETH_W = 8;
	localparam int PULSE_W = 8;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	// product widths of the speed datapath
	localparam int PR_W = CNT_W + RADIUS_W;          // pulses * radius
	localparam int DEN_W = CNT_W + TEETH_W;          // teeth * ticks
	localparam int SCALE_W = 24;
	localparam int HALF_W = 17;                      // split of PR_W for the scale multiply
	localparam int NUM_W = PR_W + SCALE_W;           // full numerator

	// mph per (m/s) in Q8.8 with radius in mm, at a 1 kHz tick
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 24'd3598;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_PULSE = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEETH = 2'd1;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd254;
	localparam logic [TEETH_W-1:0] TEETH_RESET = 8'd48;

	localparam int JOB_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [PULSE_W-1:0] pulse_count;
	} item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_q8;
		logic valid_res;
	} result_t;

	// one sample snapshot handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] pulses;
		logic [CNT_W-1:0] ticks;
		logic [RADIUS_W-1:0] radius;
		logic [TEETH_W-1:0] teeth;
	} job_t;

endpackage

[hw/rtl/wheel_speed_from_pulses_unit.sv]
// wheel speed from reluctor-wheel pulses
//
// input side is a queue: a word on item is taken when push is high and full is
// low. operation tick adds one to the tick counter, pulse adds pulse_count to
// the pulse counter (both saturate), sample snapshots both counters with the
// radius and teeth registers and clears the counters. code 3 is ignored.
// ticks and pulses are taken every clock while full is low; full rises only
// when the sample queue between the counters and the divider is full.
// result side is a queue too: while empty is low the oldest result word is on
// result, and pop takes it. only samples produce a result word.
// speed = pulses*radius*scale / (teeth*ticks) in Q8.8 mph, saturated; a zero
// operand gives speed 0 with valid_res low.
// the divide is skipped on a zero operand or on saturation; otherwise the
// 16-step restoring divider runs, and the back end takes the next sample
// only once the result word of the last one has gone to the result queue.
// a stalled result side fills the result queue, then the sample queue, then
// raises full; nothing is dropped.
// cfg_we writes radius (index 0) or teeth (index 1) at once; other indexes
// are ignored. reset restores radius 254, teeth 48 and clears all counters
// and queues.
module wheel_speed_from_pulses_unit #(
	parameter int JOB_DEPTH = wsp_pkg::JOB_DEPTH,
	parameter int RES_DEPTH = wsp_pkg::RES_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  wsp_pkg::item_t                 item,
	output logic                           empty,
	input  logic                           pop,
	output wsp_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsp_pkg::CFG_DATA_W-1:0] cfg_data
);

	// front to sample queue
	logic job_push;
	wsp_pkg::job_t job_in;

	// sample queue to back end
	logic job_pop, job_empty;
	wsp_pkg::job_t job_out;

	// back end to result queue
	logic res_push, res_full;
	wsp_pkg::result_t res_in;

	// counters and config registers
	wsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_push  (job_push),
		.job       (job_in)
	);

	// sample snapshots waiting for the divider
	wsp_queue #(
		.WIDTH ($bits(wsp_pkg::job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	// multiply, saturation check and divide
	wsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// finished result words toward the consumer
	wsp_queue #(
		.WIDTH ($bits(wsp_pkg::result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

[hw/rtl/wsp_queue.sv]
module wsp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/wsp_front.sv]
module wsp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  wsp_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          job_push,
	output wsp_pkg::job_t                 job
);

	logic [wsp_pkg::CNT_W-1:0] pulses_q, ticks_q;
	logic [wsp_pkg::RADIUS_W-1:0] radius_q;
	logic [wsp_pkg::TEETH_W-1:0] teeth_q;
	logic accept;
	logic [wsp_pkg::CNT_W:0] pulse_sum;

	assign accept = push && !full;
	assign pulse_sum = {1'b0, pulses_q} + (wsp_pkg::CNT_W + 1)'(item.pulse_count);

	assign job_push = accept && (item.operation == wsp_pkg::OP_SAMPLE);
	assign job.pulses = pulses_q;
	assign job.ticks = ticks_q;
	assign job.radius = radius_q;
	assign job.teeth = teeth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= wsp_pkg::RADIUS_RESET;
			teeth_q <= wsp_pkg::TEETH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wsp_pkg::REG_RADIUS: radius_q <= cfg_data;
				wsp_pkg::REG_TEETH:  teeth_q <= cfg_data[wsp_pkg::TEETH_W-1:0];
				default: ;
			endcase
		end
	end

	// saturating counters, cleared by a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_q <= '0;
			ticks_q <= '0;
		end else if (accept) begin
			case (item.operation)
				wsp_pkg::OP_TICK: begin
					if (ticks_q != wsp_pkg::CNT_MAX) begin
						ticks_q <= ticks_q + 1'b1;
					end
				end
				wsp_pkg::OP_PULSE: begin
					pulses_q <= pulse_sum[wsp_pkg::CNT_W] ? wsp_pkg::CNT_MAX
						: pulse_sum[wsp_pkg::CNT_W-1:0];
				end
				wsp_pkg::OP_SAMPLE: begin
					pulses_q <= '0;
					ticks_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/wsp_back.sv]
module wsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_empty,
	input  wsp_pkg::job_t     job,
	output logic              job_pop,
	input  logic              res_full,
	output logic              res_push,
	output wsp_pkg::result_t  res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam int PR_W = wsp_pkg::PR_W;
	localparam int DEN_W = wsp_pkg::DEN_W;
	localparam int NUM_W = wsp_pkg::NUM_W;
	localparam int HALF_W = wsp_pkg::HALF_W;
	localparam int SPEED_W = wsp_pkg::SPEED_W;
	localparam int LO_W = HALF_W + wsp_pkg::SCALE_W;

	logic [2:0] state_q;
	wsp_pkg::job_t job_q;
	logic zero_q;
	logic [PR_W-1:0] pr_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [SPEED_W-1:0] quo_q;
	logic [3:0] step_q;
	wsp_pkg::result_t res_q;

	logic [LO_W-1:0] part_lo, part_hi;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_diff;
	logic fits;

	assign part_lo = LO_W'(pr_q[HALF_W-1:0]) * LO_W'(wsp_pkg::SPEED_SCALE);
	assign part_hi = LO_W'(pr_q[PR_W-1:HALF_W]) * LO_W'(wsp_pkg::SPEED_SCALE);

	// one restoring step: bring the next dividend bit down
	assign trial = {rem_q, quo_q[SPEED_W-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign fits = !trial_diff[DEN_W];

	assign job_pop = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;
	assign res = res_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: job_q <= job;
			ST_MUL1: begin
				pr_q <= PR_W'(job_q.pulses) * PR_W'(job_q.radius);
				den_q <= DEN_W'(job_q.ticks) * DEN_W'(job_q.teeth);
				zero_q <= (job_q.pulses == '0) || (job_q.ticks == '0)
					|| (job_q.radius == '0) || (job_q.teeth == '0);
			end
			ST_MUL2: num_q <= NUM_W'(part_lo);
			ST_MUL3: num_q <= num_q + (NUM_W'(part_hi) << HALF_W);
			ST_CHK: begin
				rem_q <= num_q[SPEED_W+DEN_W-1:SPEED_W];
				quo_q <= num_q[SPEED_W-1:0];
				if (zero_q) begin
					res_q <= '{speed_q8: '0, valid_res: 1'b0};
				end else begin
					res_q <= '{speed_q8: wsp_pkg::SPEED_MAX, valid_res: 1'b1};
				end
			end
			ST_DIV: begin
				rem_q <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[SPEED_W-2:0], fits};
				res_q <= '{speed_q8: {quo_q[SPEED_W-2:0], fits}, valid_res: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (!job_empty) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_CHK;
				ST_CHK: begin
					// zero operand or quotient at or above full scale skip the divide
					if (zero_q || (num_q[NUM_W-1:SPEED_W] >= (NUM_W - SPEED_W)'(den_q))) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
						step_q <= 4'(SPEED_W - 1);
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_OUT;
				end
				ST_OUT: if (!res_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !res_q.valid_res) |-> (res_q.speed_q8 == '0))
		else $error("invalid result with nonzero speed");
	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1) |-> ($past(state_q) == ST_IDLE && $past(!job_empty)))
		else $error("datapath started without a job");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && res_full) |=> (state_q == ST_OUT && $stable(res_q)))
		else $error("result lost while result queue full");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	// codes the package leaves unnamed
	localparam logic [wsp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [wsp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [wsp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int STALL_LIMIT = 5000;   // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 40;    // longest sample latency plus margin
	localparam int PRINT_LIMIT = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	wsp_pkg::item_t item;
	logic empty;
	logic pop;
	wsp_pkg::result_t result;
	logic cfg_we;
	logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wsp_pkg::CFG_DATA_W-1:0] cfg_data;

	// model of the block
	logic [wsp_pkg::RADIUS_W-1:0] radius_reg;
	logic [wsp_pkg::TEETH_W-1:0] teeth_reg;
	logic [wsp_pkg::CNT_W-1:0] pulse_sum;
	logic [wsp_pkg::CNT_W-1:0] tick_sum;
	wsp_pkg::result_t speed_words_due[$];

	int mismatch_count = 0;
	int stall_cycles = 0;
	int pop_rest = 0;
	bit idle_on = 1'b1;

	wheel_speed_from_pulses_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
	endtask

	// 24-bit add that sticks at the counter maximum
	function automatic logic [wsp_pkg::CNT_W-1:0] add_sat(input logic [wsp_pkg::CNT_W-1:0] a,
			input logic [wsp_pkg::CNT_W-1:0] b);
		logic [wsp_pkg::CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[wsp_pkg::CNT_W] ? wsp_pkg::CNT_MAX : s[wsp_pkg::CNT_W-1:0];
	endfunction

	// advance the model by one accepted item; a sample queues its speed word
	task automatic predict_speed(input wsp_pkg::item_t w);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		wsp_pkg::result_t r;
		case (w.operation)
			wsp_pkg::OP_TICK: begin
				tick_sum = add_sat(tick_sum, wsp_pkg::CNT_W'(1));
			end
			wsp_pkg::OP_PULSE: begin
				pulse_sum = add_sat(pulse_sum, wsp_pkg::CNT_W'(w.pulse_count));
			end
			wsp_pkg::OP_SAMPLE: begin
				r = '0;
				// any zero operand gives speed 0 with valid low
				if (radius_reg != '0 && teeth_reg != '0 && pulse_sum != '0
						&& tick_sum != '0) begin
					num = 64'(pulse_sum) * 64'(radius_reg) * 64'(wsp_pkg::SPEED_SCALE);
					den = 64'(teeth_reg) * 64'(tick_sum);
					quo = num / den;
					r.speed_q8 = (quo > 64'(wsp_pkg::SPEED_MAX)) ? wsp_pkg::SPEED_MAX
						: quo[wsp_pkg::SPEED_W-1:0];
					r.valid_res = 1'b1;
				end
				speed_words_due.push_back(r);
				pulse_sum = '0;
				tick_sum = '0;
			end
			default: begin
				// unused code: no state change, no word
			end
		endcase
	endtask

	// called at a falling edge, returns at the falling edge after acceptance;
	// push stays high so back-to-back words need no second assignment
	task automatic send_word(input logic [wsp_pkg::OP_W-1:0] op,
			input logic [wsp_pkg::PULSE_W-1:0] count);
		wsp_pkg::item_t w;
		w.operation = op;
		w.pulse_count = count;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		predict_speed(w);
		@(negedge clk);
	endtask

	// mostly small counts so speeds land below saturation, sometimes any byte
	function automatic logic [wsp_pkg::PULSE_W-1:0] pick_count();
		if ($urandom_range(0, 3) != 0) begin
			return wsp_pkg::PULSE_W'($urandom_range(0, 3));
		end
		return wsp_pkg::PULSE_W'($urandom);
	endfunction

	// let every predicted word come out, then cover the divider latency
	task automatic wait_drained();
		push <= 1'b0;
		while (speed_words_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one register write per cycle; the caller lowers cfg_we after the last one
	task automatic write_reg(input logic [wsp_pkg::CFG_IDX_W-1:0] idx,
			input logic [wsp_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			wsp_pkg::REG_RADIUS: radius_reg = val[wsp_pkg::RADIUS_W-1:0];
			wsp_pkg::REG_TEETH: teeth_reg = val[wsp_pkg::TEETH_W-1:0];
			default: begin
				// index past the register list is dropped
			end
		endcase
	endtask

	// new wheel geometry, written only once the block is quiet
	task automatic set_wheel(input logic [wsp_pkg::RADIUS_W-1:0] radius,
			input logic [wsp_pkg::TEETH_W-1:0] teeth);
		wait_drained();
		write_reg(REG_SPARE_A, wsp_pkg::CFG_DATA_W'($urandom));
		write_reg(wsp_pkg::REG_RADIUS, radius);
		// upper data bits are junk for the 8-bit teeth register
		write_reg(wsp_pkg::REG_TEETH, {2'($urandom_range(0, 3)), teeth});
		write_reg(REG_SPARE_B, wsp_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// short hand-picked sequences at the reset geometry
	task automatic test_directed_cases();
		// sample with both counters at zero
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
		// one tick with a stray count, full pulse byte, zero pulse byte: speed saturates
		send_word(wsp_pkg::OP_TICK, 8'hFF);
		send_word(wsp_pkg::OP_PULSE, 8'hFF);
		send_word(wsp_pkg::OP_PULSE, 8'h00);
		send_word(wsp_pkg::OP_SAMPLE, 8'hFF);
		// unused code in the middle of a normal measurement
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(OP_UNUSED, 8'hFF);
		send_word(wsp_pkg::OP_TICK, 8'hAA);
		send_word(wsp_pkg::OP_PULSE, 8'h01);
		send_word(OP_UNUSED, 8'h00);
		send_word(wsp_pkg::OP_SAMPLE, 8'h55);
		// pulses with no ticks
		send_word(wsp_pkg::OP_PULSE, 8'h05);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
		// ticks with no pulses
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
	endtask

	// zero radius and zero teeth each void a sample; then both registers at their tops
	task automatic test_zero_registers();
		set_wheel(10'd0, 8'd48);
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_PULSE, 8'h03);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
		set_wheel(10'd1023, 8'd0);
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_PULSE, 8'h03);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
		set_wheel(10'd1023, 8'd255);
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_PULSE, 8'h02);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
	endtask

	// runs of full pulse bytes on a small wheel; radius 1 and teeth 255 keep the
	// quotient below saturation so a bad carry in the counter would show
	task automatic test_large_counts();
		set_wheel(10'd1, 8'd255);
		repeat (50) send_word(wsp_pkg::OP_PULSE, 8'hFF);
		repeat (50) send_word(wsp_pkg::OP_TICK, wsp_pkg::PULSE_W'($urandom));
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
		// counters must start over after the sample
		send_word(wsp_pkg::OP_TICK, 8'h00);
		send_word(wsp_pkg::OP_PULSE, 8'h07);
		send_word(wsp_pkg::OP_SAMPLE, 8'h00);
	endtask

	// mostly whole measurements (ticks with pulses mixed in, then a sample),
	// sometimes loose words of any code
	task automatic run_phase(input logic [wsp_pkg::RADIUS_W-1:0] radius,
			input logic [wsp_pkg::TEETH_W-1:0] teeth, input int words);
		int sent;
		int ticks;
		logic [wsp_pkg::OP_W-1:0] op;
		sent = 0;
		set_wheel(radius, teeth);
		while (sent < words) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					op = wsp_pkg::OP_W'($urandom_range(0, 3));
					send_word(op, wsp_pkg::PULSE_W'($urandom));
					if (op != OP_UNUSED) sent++;
				end
			end else begin
				ticks = $urandom_range(1, 30);
				repeat (ticks) begin
					send_word(wsp_pkg::OP_TICK, wsp_pkg::PULSE_W'($urandom));
					sent++;
					if ($urandom_range(0, 2) == 0) begin
						send_word(wsp_pkg::OP_PULSE, pick_count());
						sent++;
					end
				end
				send_word(wsp_pkg::OP_SAMPLE, wsp_pkg::PULSE_W'($urandom));
				sent++;
			end
		end
	endtask

	task automatic test_random_phases();
		run_phase(10'd254, 8'd48, 250);
		run_phase(10'd1023, 8'd255, 250);
		run_phase(10'd1, 8'd1, 250);
		run_phase(10'd1023, 8'd1, 250);
		run_phase(wsp_pkg::RADIUS_W'($urandom_range(0, 1023)),
			wsp_pkg::TEETH_W'($urandom_range(0, 255)), 250);
		// last stretch runs at full rate on both sides
		wait_drained();
		idle_on = 1'b0;
		run_phase(wsp_pkg::RADIUS_W'($urandom_range(1, 1023)),
			wsp_pkg::TEETH_W'($urandom_range(1, 255)), 250);
	endtask

	// result side: pop held high except for random stall bursts
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (pop_rest > 0) begin
				pop_rest--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				pop_rest = $urandom_range(0, 5);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// compare each popped word with the oldest predicted one
	always @(posedge clk) begin : check_words
		wsp_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (speed_words_due.size() == 0) begin
				report_mismatch($sformatf("word with none due: speed %0d valid %0b",
					result.speed_q8, result.valid_res));
			end else begin
				want = speed_words_due.pop_front();
				if (result.speed_q8 !== want.speed_q8) begin
					report_mismatch($sformatf("speed_q8 %0d, want %0d",
						result.speed_q8, want.speed_q8));
				end
				if (result.valid_res !== want.valid_res) begin
					report_mismatch($sformatf("valid_res %0b, want %0b",
						result.valid_res, want.valid_res));
				end
			end
		end
	end

	// nothing moving on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		radius_reg = wsp_pkg::RADIUS_RESET;
		teeth_reg = wsp_pkg::TEETH_RESET;
		pulse_sum = '0;
		tick_sum = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_zero_registers();
		test_large_counts();
		test_random_phases();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
